/* hdl/swbrm_pkg.sv */
// Shared widths and constants for the sliding-window byte-rate meter.
`timescale 1ns / 1ps

package swbrm_pkg;

  localparam int TIME_W      = 32;
  localparam int BYTES_W     = 32;
  localparam int WIN_W       = 16;
  localparam int TOTAL_W     = 38;
  localparam int RATE_W      = 41;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TUSER_W = 1;
  localparam int SAMPLE_W    = TIME_W + BYTES_W;
  localparam int DIV_STEP_W  = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Record or query, from the lowest bit of the input tuser
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

endpackage

/* hdl/swbrm_ram.sv */
// Sample store for both rings: one write port, one registered read port.
`timescale 1ns / 1ps

module swbrm_ram #(
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [swbrm_pkg::SAMPLE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [swbrm_pkg::SAMPLE_W-1:0] rdata
);

  logic [swbrm_pkg::SAMPLE_W-1:0] mem [2**ADDR_W];
  logic [swbrm_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/swbrm_div.sv */
// Restoring serial divider, one quotient bit per cycle, for the rate.
`timescale 1ns / 1ps

module swbrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [swbrm_pkg::RATE_W-1:0]  dividend,
  input  logic [swbrm_pkg::WIN_W-1:0]   divisor,
  output logic                          done,
  output logic [swbrm_pkg::RATE_W-1:0]  quotient
);

  localparam int RW = swbrm_pkg::RATE_W;
  localparam int WW = swbrm_pkg::WIN_W;
  localparam int SW = swbrm_pkg::DIV_STEP_W;

  logic [RW-1:0] quo_r, quo_nxt;
  logic [WW-1:0] rem_r, rem_nxt;
  logic [WW-1:0] div_r, div_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [WW:0]   trial;
  logic [WW:0]   diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[RW-1]};
    diff     = trial - {1'b0, div_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[WW-1:0];
        quo_nxt = {quo_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WW-1:0];
        quo_nxt = {quo_r[RW-2:0], 1'b0};
      end
      if (step_r == SW'(RW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/sliding_window_byte_rate_meter.sv */
// Top level: sequencer, ring pointers, shared age compare and accumulator.
`timescale 1ns / 1ps
//
// Byte-rate meter over a sliding window, one sample ring per channel.
// Input stream: in_tuser = {channel, mode}; in_tdata = {window_ms,
// byte_count, now_ms}. mode 0 records a sample, mode 1 queries the rate.
// Output stream: one request per input request; out_tdata = {pad,
// rate_kbps, total_bytes}, out_tuser = ring_overflow.
// One item at a time: in_tready is high only while the sequencer idles.
// Record: each expired sample is dropped by a ring read (S_PRD) and an
// age check (S_PCHK); S_FULL frees the oldest slot of a full ring, S_WR
// writes the sample and S_DONE hands over. Query: one ring read per stored
// sample through the single RAM read port, a drain of the last read,
// the serial divider and the hand-over in S_DONE.
// Ages of both item kinds go through the one subtract-and-compare.
// Reset empties both rings at once (pointers only, no sweep); sample
// entries are never read before being written.
// A result waits in the output register while out_tready is low; the
// sequencer holds its finished result until that register frees.
//
module sliding_window_byte_rate_meter #(
  parameter int RING_DEPTH = 64,
  parameter int RETAIN_MS  = 5000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] now_ms, [63:32] byte_count, [79:64] window_ms
  input  logic [swbrm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] mode, [1] channel
  input  logic [swbrm_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [37:0] total_bytes, [78:38] rate_kbps, [79] zero
  output logic [swbrm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] ring_overflow
  output logic [swbrm_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int IW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int TW    = swbrm_pkg::TIME_W;
  localparam int BW    = swbrm_pkg::BYTES_W;
  localparam int WW    = swbrm_pkg::WIN_W;
  localparam int TOTW  = swbrm_pkg::TOTAL_W;
  localparam int RW    = swbrm_pkg::RATE_W;
  localparam int ACC_W = (BW + CW > TOTW) ? BW + CW : TOTW;

  localparam logic [TW-1:0] RETAIN_LIM = TW'(RETAIN_MS);
  localparam logic [IW-1:0] LAST_IDX   = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C    = CW'(RING_DEPTH);
  localparam logic [CW:0]   DEPTH_S    = (CW + 1)'(RING_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_PRD, S_PCHK, S_FULL, S_WR, S_QSCAN, S_QDIV, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic            mode_r, mode_nxt;
  logic            ch_r, ch_nxt;
  logic [TW-1:0]   now_r, now_nxt;
  logic [BW-1:0]   bytes_r, bytes_nxt;
  logic [WW-1:0]   win_r, win_nxt;
  logic [IW-1:0]   head_r [2];
  logic [IW-1:0]   head_nxt [2];
  logic [CW-1:0]   cnt_r [2];
  logic [CW-1:0]   cnt_nxt [2];
  logic [IW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic            rdv_r, rdv_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic            flag_r, flag_nxt;
  logic [TOTW-1:0] total_r, total_nxt;
  logic [RW-1:0]   rate_r, rate_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [TOTW-1:0] out_total_r, out_total_nxt;
  logic [RW-1:0]   out_rate_r, out_rate_nxt;
  logic            out_flag_r, out_flag_nxt;

  logic                          we;
  logic [IW:0]                   waddr;
  logic [IW:0]                   raddr;
  logic [swbrm_pkg::SAMPLE_W-1:0] rdata;
  logic [TW-1:0]                 age;
  logic [TW-1:0]                 thr;
  logic                          age_ok;
  logic [CW:0]                   wsum;
  logic [IW-1:0]                 wslot;
  logic [TOTW-1:0]               total_sat;
  logic                          div_start;
  logic                          div_done;
  logic [RW-1:0]                 div_q;
  logic                          in_ch;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    wrap_inc = (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  swbrm_ram #(
    .ADDR_W (IW + 1)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({bytes_r, now_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  swbrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({total_sat, 3'b000}),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared age compare: retention limit on records, window on queries
  assign age    = now_r - rdata[TW-1:0];
  assign thr    = (mode_r == swbrm_pkg::MODE_QUERY) ? TW'(win_r) : RETAIN_LIM;
  assign age_ok = (age <= thr);

  assign wsum  = (CW + 1)'(head_r[ch_r]) + (CW + 1)'(cnt_r[ch_r]);
  assign wslot = (wsum >= DEPTH_S) ? IW'(wsum - DEPTH_S) : IW'(wsum);
  assign waddr = {ch_r, wslot};

  assign total_sat = (acc_r > ACC_W'(swbrm_pkg::TOTAL_MAX)) ?
                     swbrm_pkg::TOTAL_MAX : acc_r[TOTW-1:0];

  assign in_ch = in_tuser[1];

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ch_nxt        = ch_r;
    now_nxt       = now_r;
    bytes_nxt     = bytes_r;
    win_nxt       = win_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    rdv_nxt       = 1'b0;
    acc_nxt       = acc_r;
    flag_nxt      = flag_r;
    total_nxt     = total_r;
    rate_nxt      = rate_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_total_nxt = out_total_r;
    out_rate_nxt  = out_rate_r;
    out_flag_nxt  = out_flag_r;
    we            = 1'b0;
    raddr         = {ch_r, head_r[ch_r]};
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser[0];
          ch_nxt    = in_ch;
          now_nxt   = in_tdata[TW-1:0];
          bytes_nxt = in_tdata[TW+BW-1:TW];
          win_nxt   = in_tdata[TW+BW+WW-1:TW+BW];
          flag_nxt  = 1'b0;
          total_nxt = '0;
          rate_nxt  = '0;
          if (in_tuser[0] == swbrm_pkg::MODE_QUERY) begin
            ptr_nxt   = head_r[in_ch];
            left_nxt  = cnt_r[in_ch];
            acc_nxt   = '0;
            state_nxt = S_QSCAN;
          end else begin
            state_nxt = S_PRD;
          end
        end
      end
      S_PRD: begin
        state_nxt = (cnt_r[ch_r] == '0) ? S_FULL : S_PCHK;
      end
      S_PCHK: begin
        if (age_ok) begin
          state_nxt = S_FULL;
        end else begin
          head_nxt[ch_r] = wrap_inc(head_r[ch_r]);
          cnt_nxt[ch_r]  = cnt_r[ch_r] - 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_FULL: begin
        if (cnt_r[ch_r] >= DEPTH_C) begin
          head_nxt[ch_r] = wrap_inc(head_r[ch_r]);
          cnt_nxt[ch_r]  = DEPTH_C - 1'b1;
          flag_nxt       = 1'b1;
        end
        state_nxt = S_WR;
      end
      S_WR: begin
        we            = 1'b1;
        cnt_nxt[ch_r] = cnt_r[ch_r] + 1'b1;
        state_nxt     = S_DONE;
      end
      S_QSCAN: begin
        raddr = {ch_r, ptr_r};
        if (left_r != '0) begin
          ptr_nxt  = wrap_inc(ptr_r);
          left_nxt = left_r - 1'b1;
          rdv_nxt  = 1'b1;
        end
        if (rdv_r && age_ok) begin
          acc_nxt = acc_r + ACC_W'(rdata[swbrm_pkg::SAMPLE_W-1:TW]);
        end
        if (left_r == '0 && !rdv_r) begin
          total_nxt = total_sat;
          div_start = 1'b1;
          state_nxt = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          rate_nxt  = (win_r == '0) ? '0 : div_q;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          out_rate_nxt  = rate_r;
          out_flag_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    ch_r        <= ch_nxt;
    now_r       <= now_nxt;
    bytes_r     <= bytes_nxt;
    win_r       <= win_nxt;
    ptr_r       <= ptr_nxt;
    left_r      <= left_nxt;
    acc_r       <= acc_nxt;
    flag_r      <= flag_nxt;
    total_r     <= total_nxt;
    rate_r      <= rate_nxt;
    out_total_r <= out_total_nxt;
    out_rate_r  <= out_rate_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rate_r, out_total_r};
  assign out_tuser  = out_flag_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= DEPTH_C && cnt_r[1] <= DEPTH_C)
    else $error("ring count beyond depth");

  a_query_keeps_rings: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QSCAN || state_r == S_QDIV) |=>
      $stable(cnt_r[0]) && $stable(cnt_r[1]) &&
      $stable(head_r[0]) && $stable(head_r[1]))
    else $error("query changed ring pointers");

  a_overflow_zero_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("overflowing record carries a nonzero total or rate");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rdv_r |-> state_r == S_QSCAN)
    else $error("scan read outstanding outside scan");

endmodule
